// ===== rtl/tdts_pkg.sv =====
// Shared types and constants for the token scanner.
package tdts_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    CL_LETTER, CL_DIGIT, CL_PLUS, CL_MINUS, CL_LPAREN, CL_RPAREN,
    CL_COMMA, CL_SEMI, CL_COLON, CL_EQUAL, CL_SPACE, CL_OTHER
  } char_class_t;

  typedef enum logic [3:0] {
    ST_START = 4'd0,
    ST_IDENT = 4'd1,
    ST_CONST = 4'd3,
    ST_COLON = 4'd11
  } scan_state_t;

  typedef enum logic [3:0] {
    TK_BEGIN  = 4'd0,
    TK_END    = 4'd1,
    TK_READ   = 4'd2,
    TK_WRITE  = 4'd3,
    TK_IDENT  = 4'd4,
    TK_CONST  = 4'd5,
    TK_PLUS   = 4'd6,
    TK_MINUS  = 4'd7,
    TK_LPAREN = 4'd8,
    TK_RPAREN = 4'd9,
    TK_COMMA  = 4'd10,
    TK_SEMI   = 4'd11,
    TK_ASSIGN = 4'd12,
    TK_LEXERR = 4'd13,
    TK_EOF    = 4'd14
  } token_kind_t;

  typedef logic [0:7][7:0] word_t;

  localparam word_t KW_BEGIN_TEXT = {"inicio", 16'h0000};
  localparam word_t KW_END_TEXT   = {"fin", 40'h00_0000_0000};
  localparam word_t KW_READ_TEXT  = {"leer", 32'h0000_0000};
  localparam word_t KW_WRITE_TEXT = "escribir";

  typedef struct packed {
    logic        end_mark;
    char_class_t cls;
    logic [7:0]  char_code;
  } scan_item_t;

  typedef struct packed {
    token_kind_t kind;
    logic [30:0] value;
    logic [9:0]  len;
  } token_t;

endpackage

// ===== rtl/tdts_front.sv =====
// Front end: classifies incoming characters and queues them for the scanner.
module tdts_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  logic [7:0]          char_code,
  input  logic                end_mark,
  output logic                q_valid,
  output tdts_pkg::scan_item_t q_head,
  input  logic                q_pop
);
  import tdts_pkg::*;

  scan_item_t            queue [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QCNT_W-1:0]     count;
  logic                  push;
  scan_item_t            item;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      r = CL_LETTER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = CL_DIGIT;
    end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      r = CL_SPACE;
    end else begin
      case (c)
        8'h2B:   r = CL_PLUS;
        8'h2D:   r = CL_MINUS;
        8'h28:   r = CL_LPAREN;
        8'h29:   r = CL_RPAREN;
        8'h2C:   r = CL_COMMA;
        8'h3B:   r = CL_SEMI;
        8'h3A:   r = CL_COLON;
        8'h3D:   r = CL_EQUAL;
        default: r = CL_OTHER;
      endcase
    end
    return r;
  endfunction

  assign src_stall = (count == QCNT_W'(QDEPTH));
  assign push      = src_valid && !src_stall;
  assign q_valid   = (count != '0);
  assign q_head    = queue[rd_ptr];

  always_comb begin
    item.end_mark  = end_mark;
    item.cls       = classify(char_code);
    item.char_code = char_code;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/tdts_back.sv =====
// Back end: scanner state machine, keyword match and token output buffer.
module tdts_back #(
  parameter int MAX_TOKEN_LEN = 1023
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  tdts_pkg::scan_item_t q_head,
  output logic                 q_pop,
  output logic                 tok_valid,
  input  logic                 tok_stall,
  output tdts_pkg::token_t     tok,
  output logic                 tok_last
);
  import tdts_pkg::*;

  localparam logic [9:0] LEN_CAP = 10'((MAX_TOKEN_LEN < 1023) ? MAX_TOKEN_LEN : 1023);

  scan_state_t state;
  scan_state_t state_next;
  word_t       word;
  word_t       word_next;
  logic [9:0]  len;
  logic [9:0]  len_next;
  logic [30:0] acc;
  logic [30:0] acc_next;
  logic [34:0] acc_x10;
  logic [30:0] acc_sat;

  logic        flush_v;
  token_t      flush_tok;
  logic        new_v;
  token_t      new_tok;
  logic        restart;
  logic        alnum;
  logic        is_digit;
  logic [1:0]  n_tok;
  token_t      slot0;

  token_t      pend;
  logic        pend_valid;
  logic        out_take;
  logic        out_free;
  logic        fire;

  function automatic token_kind_t kw_kind(input word_t w, input logic [9:0] l);
    token_kind_t k;
    k = TK_IDENT;
    if (l == 10'd6 && w == KW_BEGIN_TEXT) k = TK_BEGIN;
    if (l == 10'd3 && w == KW_END_TEXT)   k = TK_END;
    if (l == 10'd4 && w == KW_READ_TEXT)  k = TK_READ;
    if (l == 10'd8 && w == KW_WRITE_TEXT) k = TK_WRITE;
    return k;
  endfunction

  function automatic scan_state_t start_state(input char_class_t c);
    scan_state_t s;
    case (c)
      CL_LETTER: s = ST_IDENT;
      CL_DIGIT:  s = ST_CONST;
      CL_COLON:  s = ST_COLON;
      default:   s = ST_START;
    endcase
    return s;
  endfunction

  assign is_digit = (q_head.cls == CL_DIGIT);
  assign alnum    = (q_head.cls == CL_LETTER) || is_digit;

  assign acc_x10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, q_head.char_code[3:0]};
  assign acc_sat = (acc_x10 > {4'b0, NUM_MAX}) ? NUM_MAX : acc_x10[30:0];

  // next state
  always_comb begin
    state_next = state;
    if (q_head.end_mark) begin
      state_next = ST_START;
    end else begin
      case (state)
        ST_IDENT: if (!alnum) state_next = start_state(q_head.cls);
        ST_CONST: if (!is_digit) state_next = start_state(q_head.cls);
        ST_COLON: state_next = ST_START;
        default:  state_next = start_state(q_head.cls);
      endcase
    end
  end

  // tokens and datapath updates
  always_comb begin
    word_next = word;
    len_next  = len;
    acc_next  = acc;
    flush_v   = 1'b0;
    flush_tok = '{kind: TK_LEXERR, value: '0, len: '0};
    new_v     = 1'b0;
    new_tok   = '{kind: TK_LEXERR, value: '0, len: '0};
    restart   = 1'b0;
    if (q_head.end_mark) begin
      case (state)
        ST_IDENT: begin
          flush_v   = 1'b1;
          flush_tok = '{kind: kw_kind(word, len), value: '0, len: len};
        end
        ST_CONST: begin
          flush_v   = 1'b1;
          flush_tok = '{kind: TK_CONST, value: acc, len: len};
        end
        ST_COLON: flush_v = 1'b1;
        default:  flush_v = 1'b0;
      endcase
      new_v        = 1'b1;
      new_tok.kind = TK_EOF;
    end else begin
      case (state)
        ST_IDENT: begin
          if (alnum) begin
            if (len < 10'd8) word_next[len[2:0]] = q_head.char_code;
            if (len < LEN_CAP) len_next = len + 10'd1;
          end else begin
            flush_v   = 1'b1;
            flush_tok = '{kind: kw_kind(word, len), value: '0, len: len};
            restart   = 1'b1;
          end
        end
        ST_CONST: begin
          if (is_digit) begin
            acc_next = acc_sat;
            if (len < LEN_CAP) len_next = len + 10'd1;
          end else begin
            flush_v   = 1'b1;
            flush_tok = '{kind: TK_CONST, value: acc, len: len};
            restart   = 1'b1;
          end
        end
        ST_COLON: begin
          flush_v        = 1'b1;
          flush_tok.kind = (q_head.cls == CL_EQUAL) ? TK_ASSIGN : TK_LEXERR;
        end
        default: restart = 1'b1;
      endcase
    end
    if (restart) begin
      case (q_head.cls)
        CL_LETTER: begin
          word_next    = '0;
          word_next[0] = q_head.char_code;
          len_next     = 10'd1;
        end
        CL_DIGIT: begin
          acc_next = {27'b0, q_head.char_code[3:0]};
          len_next = 10'd1;
        end
        CL_PLUS:   begin new_v = 1'b1; new_tok.kind = TK_PLUS;   end
        CL_MINUS:  begin new_v = 1'b1; new_tok.kind = TK_MINUS;  end
        CL_LPAREN: begin new_v = 1'b1; new_tok.kind = TK_LPAREN; end
        CL_RPAREN: begin new_v = 1'b1; new_tok.kind = TK_RPAREN; end
        CL_COMMA:  begin new_v = 1'b1; new_tok.kind = TK_COMMA;  end
        CL_SEMI:   begin new_v = 1'b1; new_tok.kind = TK_SEMI;   end
        CL_COLON:  new_v = 1'b0;
        CL_SPACE:  new_v = 1'b0;
        default:   begin new_v = 1'b1; new_tok.kind = TK_LEXERR; end
      endcase
    end
  end

  assign n_tok    = {1'b0, flush_v} + {1'b0, new_v};
  assign slot0    = flush_v ? flush_tok : new_tok;
  assign out_take = tok_valid && !tok_stall;
  assign out_free = !tok_valid || out_take;
  assign fire     = q_valid && !pend_valid && ((n_tok == 2'd0) || out_free);
  assign q_pop    = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
      word  <= '0;
      len   <= '0;
      acc   <= '0;
    end else if (fire) begin
      state <= state_next;
      word  <= word_next;
      len   <= len_next;
      acc   <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid && out_take) begin
      pend_valid <= 1'b0;
    end else if (fire && n_tok != 2'd0) begin
      tok_valid  <= 1'b1;
      pend_valid <= (n_tok == 2'd2);
    end else if (out_take) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && out_take) begin
      tok      <= pend;
      tok_last <= 1'b1;
    end else if (fire && n_tok != 2'd0) begin
      tok      <= slot0;
      tok_last <= (n_tok == 2'd1);
      pend     <= new_tok;
    end
  end

endmodule

// ===== rtl/table_driven_token_scanner_unit.sv =====
// The first token of a character is registered at the output; a second waits in a pending register.
// Throughput: one character per cycle unless the output stalls or a second token is pending.
// The rate is set by the scanner step on the head of the 4-entry character queue.
// The queue keeps taking characters while the token output is stalled, until it is full.
// Reset (synchronous, active high) empties the queue and output and returns the scanner to start.
module table_driven_token_scanner_unit #(
  parameter int MAX_TOKEN_LEN = 1023
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [7:0]  char_code,
  input  logic        end_mark,
  output logic        tok_valid,
  input  logic        tok_stall,
  output logic [3:0]  token_kind,
  output logic [30:0] const_value,
  output logic [9:0]  ident_length,
  output logic        last_of_run
);
  import tdts_pkg::*;

  logic       q_valid;
  scan_item_t q_head;
  logic       q_pop;
  token_t     tok;

  tdts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .char_code (char_code),
    .end_mark  (end_mark),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  tdts_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok),
    .tok_last  (last_of_run)
  );

  assign token_kind   = tok.kind;
  assign const_value  = tok.value;
  assign ident_length = tok.len;

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && token_kind == TK_EOF) |-> last_of_run)
    else $error("end-of-file token not last of its run");

  a_value_only_const: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && token_kind != TK_CONST) |-> (const_value == '0))
    else $error("nonzero value on non-constant token");

  a_eof_then_start: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.end_mark) |=> !(tok_valid && !last_of_run && token_kind == TK_EOF))
    else $error("end-of-file token not closing its run");

endmodule
